// ----- hw/rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assertion macros shared by the rtl
// concurrent checks compile away when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// implication or plain property, checked on every rising edge out of reset
`define BLR_ASSERT(lbl, clk_i, rst_ni, prop) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
		else $error("property failed");

// condition that must never be seen
`define BLR_ASSERT_NEVER(lbl, clk_i, rst_ni, cond) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
		else $error("forbidden condition seen");

`else

`define BLR_ASSERT(lbl, clk_i, rst_ni, prop)
`define BLR_ASSERT_NEVER(lbl, clk_i, rst_ni, cond)

`endif

`endif

// ----- hw/rtl/blr_pkg.sv -----
// ---------------------------------------------------------------------------
// blr_pkg
// types and constants of the line rasteriser
// ---------------------------------------------------------------------------
package blr_pkg;

	localparam int unsigned COORD_BITS      = 16;
	localparam int unsigned DIM_BITS        = 13;
	localparam int unsigned ADDR_BITS       = 26;
	localparam int unsigned COLOR_BITS      = 8;
	localparam int unsigned PIXEL_BYTES     = 4;
	localparam int unsigned MAX_DIM_DEFAULT = 4096;
	localparam int unsigned DELTA_BITS      = COORD_BITS + 1;
	localparam int unsigned ERR_BITS        = COORD_BITS + 2;

	localparam logic [DIM_BITS-1:0] WIDTH_RESET  = DIM_BITS'(1920);
	localparam logic [DIM_BITS-1:0] HEIGHT_RESET = DIM_BITS'(1080);

	typedef enum logic [0:0] {
		CMD_START = 1'b0,
		CMD_STEP  = 1'b1
	} cmd_t;

	typedef enum logic [0:0] {
		CFG_WIDTH  = 1'b0,
		CFG_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		cmd_t                          command;
		logic signed [COORD_BITS-1:0]  x_start;
		logic signed [COORD_BITS-1:0]  y_start;
		logic signed [COORD_BITS-1:0]  x_end;
		logic signed [COORD_BITS-1:0]  y_end;
		logic [COLOR_BITS-1:0]         red;
		logic [COLOR_BITS-1:0]         green;
		logic [COLOR_BITS-1:0]         blue;
		logic [COLOR_BITS-1:0]         alpha;
	} in_word_t;

	typedef struct packed {
		logic                          pixel_write;
		logic signed [COORD_BITS-1:0]  pixel_x;
		logic signed [COORD_BITS-1:0]  pixel_y;
		logic [ADDR_BITS-1:0]          byte_address;
		logic [COLOR_BITS-1:0]         out_red;
		logic [COLOR_BITS-1:0]         out_green;
		logic [COLOR_BITS-1:0]         out_blue;
		logic [COLOR_BITS-1:0]         out_alpha;
		logic                          line_done;
	} out_word_t;

endpackage

// ----- hw/rtl/bresenham_line_rasterizer_core.sv -----
// ---------------------------------------------------------------------------
// bresenham_line_rasterizer_core
// Bresenham line walker giving at most one frame buffer pixel write per step word.
// A start word loads endpoints and colour and gives no result; every step
// word gives one result. The core takes one word per clock while the result
// side does not stall: a word is registered at the input, then the walker
// state, the clip test and the address multiply (one 13 x 13 product plus an
// add) settle combinationally into the result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bresenham_line_rasterizer_core
	import blr_pkg::*;
#(
	parameter int unsigned MAX_DIM = MAX_DIM_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  cfg_reg_t             cfg_index,
	input  logic [DIM_BITS-1:0]  cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_word_t             in_word,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_word_t            out_word
);

	// the registers are only 13 bits wide, so a larger bound never clips
	localparam int unsigned DIM_LIMIT = (MAX_DIM > ((1 << DIM_BITS) - 1)) ?
		((1 << DIM_BITS) - 1) : MAX_DIM;
	localparam logic [DIM_BITS-1:0] DIM_CAP = DIM_BITS'(DIM_LIMIT);
	localparam int unsigned BPP_SHIFT = $clog2(PIXEL_BYTES);
	localparam int unsigned IDX_BITS  = ADDR_BITS - BPP_SHIFT;
	localparam int unsigned PROD_BITS = 2 * DIM_BITS;

	logic [DIM_BITS-1:0] screen_width_q, screen_height_q;

	logic     valid_s1;
	in_word_t word_s1;

	logic signed [COORD_BITS-1:0] cur_x_q, cur_y_q, end_x_q, end_y_q;
	logic signed [DELTA_BITS-1:0] delta_x_q, neg_delta_y_q;
	logic                         step_x_neg_q, step_y_neg_q;
	logic signed [ERR_BITS-1:0]   error_term_q;
	logic [4*COLOR_BITS-1:0]      line_color_q;
	logic                         line_active_q;

	logic advance, proc_s1, is_step;
	logic [DIM_BITS-1:0] w_lim, h_lim;
	logic on_screen, at_end;
	logic [PROD_BITS-1:0] row_base;
	logic [IDX_BITS-1:0]  pix_index;
	logic signed [ERR_BITS:0] e2, ndy_ext, dx_ext, err_sum;
	logic move_x, move_y;
	logic signed [DELTA_BITS-1:0] st_dx, st_ndy;
	logic signed [DELTA_BITS-1:0] x0_ext, y0_ext, x1_ext, y1_ext;
	out_word_t result;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= WIDTH_RESET;
			screen_height_q <= HEIGHT_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_WIDTH:  screen_width_q  <= cfg_data;
				CFG_HEIGHT: screen_height_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	assign advance  = !out_valid || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign proc_s1  = valid_s1 && advance;
	assign is_step  = (word_s1.command == CMD_STEP);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			word_s1 <= in_word;
		end
	end

	// clip bounds and pixel address
	always_comb begin
		w_lim = (screen_width_q > DIM_CAP) ? DIM_CAP : screen_width_q;
		h_lim = (screen_height_q > DIM_CAP) ? DIM_CAP : screen_height_q;
		on_screen = !cur_x_q[COORD_BITS-1] && !cur_y_q[COORD_BITS-1] &&
			({1'b0, cur_x_q} < {{(COORD_BITS+1-DIM_BITS){1'b0}}, w_lim}) &&
			({1'b0, cur_y_q} < {{(COORD_BITS+1-DIM_BITS){1'b0}}, h_lim});
		at_end = (cur_x_q == end_x_q) && (cur_y_q == end_y_q);
		row_base = cur_y_q[DIM_BITS-1:0] * w_lim;
		pix_index = IDX_BITS'(row_base + {{(PROD_BITS-DIM_BITS){1'b0}},
			cur_x_q[DIM_BITS-1:0]});
	end

	// bresenham advance
	always_comb begin
		e2      = {error_term_q, 1'b0};
		ndy_ext = {{2{neg_delta_y_q[DELTA_BITS-1]}}, neg_delta_y_q};
		dx_ext  = {{2{delta_x_q[DELTA_BITS-1]}}, delta_x_q};
		move_x  = (e2 >= ndy_ext);
		move_y  = (e2 <= dx_ext);
		err_sum = {error_term_q[ERR_BITS-1], error_term_q}
			+ (move_x ? ndy_ext : '0) + (move_y ? dx_ext : '0);
	end

	// start word setup
	always_comb begin
		x0_ext = {word_s1.x_start[COORD_BITS-1], word_s1.x_start};
		y0_ext = {word_s1.y_start[COORD_BITS-1], word_s1.y_start};
		x1_ext = {word_s1.x_end[COORD_BITS-1], word_s1.x_end};
		y1_ext = {word_s1.y_end[COORD_BITS-1], word_s1.y_end};
		st_dx  = (x1_ext >= x0_ext) ? (x1_ext - x0_ext) : (x0_ext - x1_ext);
		st_ndy = (y1_ext >= y0_ext) ? (y0_ext - y1_ext) : (y1_ext - y0_ext);
	end

	// result word
	always_comb begin
		result = '0;
		if (!line_active_q) begin
			result.line_done = 1'b1;
		end else begin
			result.pixel_write  = on_screen;
			result.pixel_x      = cur_x_q;
			result.pixel_y      = cur_y_q;
			result.byte_address = on_screen ? {pix_index, {BPP_SHIFT{1'b0}}} : '0;
			result.out_red      = line_color_q[COLOR_BITS-1:0];
			result.out_green    = line_color_q[2*COLOR_BITS-1:COLOR_BITS];
			result.out_blue     = line_color_q[3*COLOR_BITS-1:2*COLOR_BITS];
			result.out_alpha    = line_color_q[4*COLOR_BITS-1:3*COLOR_BITS];
			result.line_done    = at_end;
		end
	end

	// walker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q       <= '0;
			cur_y_q       <= '0;
			end_x_q       <= '0;
			end_y_q       <= '0;
			delta_x_q     <= '0;
			neg_delta_y_q <= '0;
			step_x_neg_q  <= 1'b0;
			step_y_neg_q  <= 1'b0;
			error_term_q  <= '0;
			line_color_q  <= '0;
			line_active_q <= 1'b0;
		end else if (proc_s1) begin
			if (!is_step) begin
				cur_x_q       <= word_s1.x_start;
				cur_y_q       <= word_s1.y_start;
				end_x_q       <= word_s1.x_end;
				end_y_q       <= word_s1.y_end;
				delta_x_q     <= st_dx;
				neg_delta_y_q <= st_ndy;
				step_x_neg_q  <= !(word_s1.x_start < word_s1.x_end);
				step_y_neg_q  <= !(word_s1.y_start < word_s1.y_end);
				error_term_q  <= {st_dx[DELTA_BITS-1], st_dx}
					+ {st_ndy[DELTA_BITS-1], st_ndy};
				line_color_q  <= {word_s1.alpha, word_s1.blue,
					word_s1.green, word_s1.red};
				line_active_q <= 1'b1;
			end else if (line_active_q) begin
				if (at_end) begin
					line_active_q <= 1'b0;
				end else begin
					error_term_q <= err_sum[ERR_BITS-1:0];
					if (move_x) begin
						cur_x_q <= step_x_neg_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
					end
					if (move_y) begin
						cur_y_q <= step_y_neg_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
					end
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= valid_s1 && is_step;
		end
	end

	always_ff @(posedge clk) begin
		if (proc_s1 && is_step) begin
			out_word <= result;
		end
	end

	`BLR_ASSERT(a_offscreen_addr_zero, clk, arst_n, (out_valid && !out_word.pixel_write) |-> (out_word.byte_address == '0))
	`BLR_ASSERT_NEVER(a_write_negative, clk, arst_n, out_valid && out_word.pixel_write && (out_word.pixel_x[COORD_BITS-1] || out_word.pixel_y[COORD_BITS-1]))
	`BLR_ASSERT(a_line_ends_on_step, clk, arst_n, $fell(line_active_q) |-> $past(proc_s1 && is_step))
	`BLR_ASSERT(a_line_starts_on_start, clk, arst_n, $rose(line_active_q) |-> $past(proc_s1 && !is_step))

endmodule
